@@ rtl/utf8v_pkg.sv @@
// utf8v_pkg: shared types, status codes and constants for the utf-8 sequence validator
// used by utf8v_step, utf8v_out_reg and utf8_sequence_validator; no dependencies
package utf8v_pkg;

    localparam logic [2:0] MAX_SEQ_LENGTH = 3'd6;

    localparam int CP_W = 31;

    localparam logic [CP_W-1:0] ASCII_MAX     = 31'd127;
    localparam logic [CP_W-1:0] SURR_LOW      = 31'h0000_D800;
    localparam logic [CP_W-1:0] SURR_HIGH     = 31'h0000_DFFF;
    localparam logic [CP_W-1:0] NONCHAR_FFFE  = 31'h0000_FFFE;
    localparam logic [CP_W-1:0] NONCHAR_FFFF  = 31'h0000_FFFF;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_END       = 3'd1,
        ST_BAD_LEAD  = 3'd2,
        ST_BAD_CONT  = 3'd3,
        ST_TRUNC     = 3'd4,
        ST_OVERLONG  = 3'd5,
        ST_SURROGATE = 3'd6,
        ST_NONCHAR   = 3'd7
    } t_status;

    typedef struct packed {
        logic [2:0]      bytes_remaining;
        logic [2:0]      expected_length;
        logic [CP_W-1:0] partial_code_point;
    } t_state;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [2:0]      seq_length;
        t_status         status;
        logic [7:0]      bad_byte;
    } t_result;

    // least code point that a sequence of this length may encode
    function automatic logic [CP_W-1:0] min_for_length(input logic [2:0] len);
        logic [CP_W-1:0] m;
        case (len)
            3'd2:    m = 31'h0000_0080;
            3'd3:    m = 31'h0000_0800;
            3'd4:    m = 31'h0001_0000;
            3'd5:    m = 31'h0020_0000;
            3'd6:    m = 31'h0400_0000;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/utf8v_step.sv @@
// utf8v_step: per-byte decode logic, from current state and one byte to next state and result
// depends on utf8v_pkg
module utf8v_step (
    input  utf8v_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    input  logic               i_eoi,
    output utf8v_pkg::t_state  o_state,
    output logic               o_res_valid,
    output utf8v_pkg::t_result o_res
);

    logic [2:0]                   lead_len;
    logic [utf8v_pkg::CP_W-1:0]   lead_bits;
    logic [utf8v_pkg::CP_W-1:0]   shifted_cp;
    logic [2:0]                   rem_dec;
    utf8v_pkg::t_state            idle_state;

    assign idle_state = '0;
    assign shifted_cp = {i_state.partial_code_point[utf8v_pkg::CP_W-7:0], i_byte[5:0]};
    assign rem_dec    = i_state.bytes_remaining - 3'd1;

    always_comb begin
        lead_len  = 3'd0;
        lead_bits = '0;
        case (i_byte) inside
            8'b110?????: begin
                lead_len  = 3'd2;
                lead_bits = {26'd0, i_byte[4:0]};
            end
            8'b1110????: begin
                lead_len  = 3'd3;
                lead_bits = {27'd0, i_byte[3:0]};
            end
            8'b11110???: begin
                lead_len  = 3'd4;
                lead_bits = {28'd0, i_byte[2:0]};
            end
            8'b111110??: begin
                lead_len  = 3'd5;
                lead_bits = {29'd0, i_byte[1:0]};
            end
            8'b1111110?: begin
                lead_len  = 3'd6;
                lead_bits = {30'd0, i_byte[0]};
            end
            default: begin
                lead_len  = 3'd0;
                lead_bits = '0;
            end
        endcase
    end

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '{code_point: '0, seq_length: 3'd0,
                        status: utf8v_pkg::ST_OK, bad_byte: 8'd0};

        if (i_state.bytes_remaining == 3'd0) begin
            if (i_eoi) begin
                o_res_valid   = 1'b1;
                o_res.status  = utf8v_pkg::ST_END;
            end else if ({23'd0, i_byte} <= utf8v_pkg::ASCII_MAX) begin
                o_res_valid      = 1'b1;
                o_res.code_point = {23'd0, i_byte};
                o_res.seq_length = 3'd1;
            end else if (lead_len == 3'd0 || lead_len > utf8v_pkg::MAX_SEQ_LENGTH) begin
                o_res_valid      = 1'b1;
                o_res.seq_length = 3'd1;
                o_res.status     = utf8v_pkg::ST_BAD_LEAD;
                o_res.bad_byte   = i_byte;
            end else begin
                o_state.expected_length    = lead_len;
                o_state.bytes_remaining    = lead_len - 3'd1;
                o_state.partial_code_point = lead_bits;
            end
        end else if (i_eoi) begin
            o_state          = idle_state;
            o_res_valid      = 1'b1;
            o_res.seq_length = i_state.expected_length;
            o_res.status     = utf8v_pkg::ST_TRUNC;
        end else if (i_byte[7:6] != 2'b10) begin
            // offending byte is consumed, not retried as a lead
            o_state          = idle_state;
            o_res_valid      = 1'b1;
            o_res.seq_length = i_state.expected_length;
            o_res.status     = utf8v_pkg::ST_BAD_CONT;
            o_res.bad_byte   = i_byte;
        end else if (rem_dec != 3'd0) begin
            o_state.bytes_remaining    = rem_dec;
            o_state.partial_code_point = shifted_cp;
        end else begin
            o_state          = idle_state;
            o_res_valid      = 1'b1;
            o_res.seq_length = i_state.expected_length;
            if (shifted_cp < utf8v_pkg::min_for_length(i_state.expected_length)) begin
                o_res.status = utf8v_pkg::ST_OVERLONG;
            end else if (shifted_cp >= utf8v_pkg::SURR_LOW
                         && shifted_cp <= utf8v_pkg::SURR_HIGH) begin
                o_res.status = utf8v_pkg::ST_SURROGATE;
            end else if (shifted_cp == utf8v_pkg::NONCHAR_FFFE
                         || shifted_cp == utf8v_pkg::NONCHAR_FFFF) begin
                o_res.status = utf8v_pkg::ST_NONCHAR;
            end else begin
                o_res.code_point = shifted_cp;
            end
        end
    end

endmodule

@@ rtl/utf8v_out_reg.sv @@
// utf8v_out_reg: result register with valid/ready handshake toward the master side
// depends on utf8v_pkg
module utf8v_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  utf8v_pkg::t_result i_res,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_can_load,
    output utf8v_pkg::t_result o_res
);

    logic               r_valid;
    utf8v_pkg::t_result r_res;

    // free when empty or when the held result leaves this cycle
    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ rtl/utf8_sequence_validator.sv @@
// utf8_sequence_validator: top level, byte stream in, decoded code points and status out
// depends on utf8v_pkg, utf8v_step and utf8v_out_reg
//
// Takes one byte per transfer and can take a new byte in every cycle while the master side
// takes results, so the rate is then one byte per clock. The decoder state (bytes still due,
// sequence length and the code point built so far) is registered from the per-byte logic,
// and each byte that ends a sequence, or ends in an error or an end status, puts one result
// into the output register, visible on the master side the cycle after the byte is taken.
// The slave side stalls only while that register holds a result the master side has
// not taken. Sequences of up to six bytes are decoded; overlong forms, surrogates and
// the noncharacters U+FFFE and U+FFFF are reported as errors, and after any error the
// next byte is treated as a lead byte.
module utf8_sequence_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_value
    input  logic        i_s_tuser,   // [0] end_of_input
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [30:0] code_point, [33:31] seq_length,
                                     // [41:34] bad_byte, [47:42] zero
    output logic [2:0]  o_m_tuser    // [2:0] status
);

    utf8v_pkg::t_state  r_state;
    utf8v_pkg::t_state  n_state;
    utf8v_pkg::t_result step_res;
    utf8v_pkg::t_result out_res;
    logic               step_res_valid;
    logic               can_load;
    logic               in_xfer;

    assign o_s_tready = can_load;
    assign in_xfer    = i_s_tvalid && can_load;

    utf8v_step u_step (
        .i_state     (r_state),
        .i_byte      (i_s_tdata),
        .i_eoi       (i_s_tuser),
        .o_state     (n_state),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    utf8v_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_xfer && step_res_valid),
        .i_res      (step_res),
        .i_ready    (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_can_load (can_load),
        .o_res      (out_res)
    );

    assign o_m_tdata = {6'd0, out_res.bad_byte, out_res.seq_length, out_res.code_point};
    assign o_m_tuser = out_res.status;

    // bytes still due never reach the length of the sequence in progress
    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_remaining != 3'd0
        |-> (r_state.bytes_remaining < r_state.expected_length
             && r_state.expected_length <= utf8v_pkg::MAX_SEQ_LENGTH))
        else $error("decoder state out of range");

    // only a clean sequence carries a code point
    a_cp_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != utf8v_pkg::ST_OK |-> o_m_tdata[30:0] == 31'd0)
        else $error("code point not zero on a non-ok result");

    // bad byte only on lead or continuation errors
    a_bad_byte_only_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != utf8v_pkg::ST_BAD_LEAD
        && o_m_tuser != utf8v_pkg::ST_BAD_CONT |-> o_m_tdata[41:34] == 8'd0)
        else $error("bad byte set on wrong status");

    // a result that ends a sequence sends the decoder back to idle
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && step_res_valid |=> r_state.bytes_remaining == 3'd0)
        else $error("decoder not idle after a result");

endmodule

@@ dv/utf8_sequence_validator_tb.sv @@
// utf8_sequence_validator_tb: self-checking bench that feeds directed and random byte streams
// and compares every decoded result against a directed table or an in-bench utf-8 decoder
// depends on utf8v_pkg and the utf8_sequence_validator rtl
module utf8_sequence_validator_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // [7:0] byte_value
    logic        i_s_tuser;    // [0] end_of_input
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;    // [30:0] code_point, [33:31] seq_length, [41:34] bad_byte
    logic [2:0]  o_m_tuser;    // [2:0] status

    typedef struct {
        logic [7:0]         b;
        logic               eoi;
        bit                 typed;
        utf8v_pkg::t_result want;
    } t_byte_row;

    t_byte_row          directed_bytes[$];
    utf8v_pkg::t_result due_results[$];
    utf8v_pkg::t_result head_result;
    int                 fail_count = 0;
    int                 bytes_sent = 0;
    bit                 calm = 1'b0;

    // decoder state mirrored in the bench
    logic [2:0]                 conts_left = '0;
    logic [2:0]                 lead_len   = '0;
    logic [utf8v_pkg::CP_W-1:0] cp_acc     = '0;

    utf8_sequence_validator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // smallest code point a sequence of n bytes may carry
    function automatic logic [utf8v_pkg::CP_W-1:0] least_code(input int n);
        case (n)
            2:       return 31'h0000_0080;
            3:       return 31'h0000_0800;
            4:       return 31'h0001_0000;
            5:       return 31'h0020_0000;
            6:       return 31'h0400_0000;
            default: return '0;
        endcase
    endfunction

    // advances the mirrored state by one byte; returns 1 when a result is due
    function automatic bit decode_byte(input logic [7:0] b, input logic eoi,
                                       output utf8v_pkg::t_result r);
        logic [2:0]                 n;
        logic [utf8v_pkg::CP_W-1:0] bits;
        r = '0;
        if (conts_left == 3'd0) begin
            if (eoi) begin
                r.status = utf8v_pkg::ST_END;
                return 1'b1;
            end
            if ({23'd0, b} <= utf8v_pkg::ASCII_MAX) begin
                r.code_point = {23'd0, b};
                r.seq_length = 3'd1;
                r.status     = utf8v_pkg::ST_OK;
                return 1'b1;
            end
            bits = '0;
            case (b) inside
                8'b110?????: begin n = 3'd2; bits[4:0] = b[4:0]; end
                8'b1110????: begin n = 3'd3; bits[3:0] = b[3:0]; end
                8'b11110???: begin n = 3'd4; bits[2:0] = b[2:0]; end
                8'b111110??: begin n = 3'd5; bits[1:0] = b[1:0]; end
                8'b1111110?: begin n = 3'd6; bits[0]   = b[0];   end
                default:     n = 3'd0;
            endcase
            if (n == 3'd0 || n > utf8v_pkg::MAX_SEQ_LENGTH) begin
                r.seq_length = 3'd1;
                r.status     = utf8v_pkg::ST_BAD_LEAD;
                r.bad_byte   = b;
                return 1'b1;
            end
            lead_len   = n;
            conts_left = n - 3'd1;
            cp_acc     = bits;
            return 1'b0;
        end
        r.seq_length = lead_len;
        if (eoi || b[7:6] != 2'b10) begin
            if (eoi) begin
                r.status   = utf8v_pkg::ST_TRUNC;
                r.bad_byte = 8'd0;
            end else begin
                r.status   = utf8v_pkg::ST_BAD_CONT;
                r.bad_byte = b;
            end
            conts_left = '0;
            lead_len   = '0;
            cp_acc     = '0;
            return 1'b1;
        end
        cp_acc     = {cp_acc[utf8v_pkg::CP_W-7:0], b[5:0]};
        conts_left = conts_left - 3'd1;
        if (conts_left != 3'd0)
            return 1'b0;
        if (cp_acc < least_code(int'(lead_len)))
            r.status = utf8v_pkg::ST_OVERLONG;
        else if (cp_acc >= utf8v_pkg::SURR_LOW && cp_acc <= utf8v_pkg::SURR_HIGH)
            r.status = utf8v_pkg::ST_SURROGATE;
        else if (cp_acc == utf8v_pkg::NONCHAR_FFFE || cp_acc == utf8v_pkg::NONCHAR_FFFF)
            r.status = utf8v_pkg::ST_NONCHAR;
        else begin
            r.status     = utf8v_pkg::ST_OK;
            r.code_point = cp_acc;
        end
        lead_len = '0;
        cp_acc   = '0;
        return 1'b1;
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic eoi, input bit typed,
                            input logic [30:0] cp, input logic [2:0] n,
                            input utf8v_pkg::t_status st, input logic [7:0] bad);
        t_byte_row row;
        row.b                = b;
        row.eoi              = eoi;
        row.typed            = typed;
        row.want.code_point  = cp;
        row.want.seq_length  = n;
        row.want.status      = st;
        row.want.bad_byte    = bad;
        directed_bytes.push_back(row);
    endtask

    // offers one byte, waits for the transfer, then books the expected result
    task automatic send_byte(input logic [7:0] b, input logic eoi, input bit typed,
                             input utf8v_pkg::t_result want);
        utf8v_pkg::t_result r;
        bit                 has;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= eoi;
        do @(posedge i_clk); while (!o_s_tready);
        has = decode_byte(b, eoi, r);
        if (typed)
            due_results.push_back(want);
        else if (has)
            due_results.push_back(r);
        bytes_sent++;
    endtask

    // one random sequence: mostly well formed, some broken, end marks and noise
    task automatic send_sequence();
        logic [7:0]  seq_bytes [0:5];
        logic [31:0] v;
        logic [31:0] top;
        logic [7:0]  junk;
        int          kind;
        int          sel;
        int          n;
        int          cut;
        kind = $urandom_range(0, 99);
        if (kind >= 82) begin
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom), 1'b0, 1'b0, '0);
            return;
        end
        if (kind >= 72) begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b1, 1'b0, '0);
            return;
        end
        sel = $urandom_range(0, 9);
        n   = (kind >= 60) ? $urandom_range(2, 6) : $urandom_range(1, 6);
        if (sel == 7 || sel == 8)
            n = 3;
        top = (n == 1) ? 32'h7F : (32'h1 << (5 * n + 1)) - 32'h1;
        case (sel)
            4:       v = (n > 1) ? $urandom_range(0, least_code(n) - 1) : $urandom & top;
            5:       v = least_code(n);
            6:       v = top;
            7:       v = $urandom_range(32'hD800, 32'hDFFF);
            8:       v = 32'hFFFE | $urandom_range(0, 1);
            9:       v = (n > 1) ? least_code(n) - 1 : top;
            default: v = $urandom & top;
        endcase
        if (n == 1)
            seq_bytes[0] = {1'b0, v[6:0]};
        else begin
            seq_bytes[0] = (8'hFF << (8 - n)) | 8'(v >> (6 * (n - 1)));
            for (int k = 1; k < n; k++)
                seq_bytes[k] = 8'h80 | 8'((v >> (6 * (n - 1 - k))) & 32'h3F);
        end
        if (kind < 60) begin
            for (int k = 0; k < n; k++)
                send_byte(seq_bytes[k], 1'b0, 1'b0, '0);
            return;
        end
        // broken: cut short by end of input or by a byte that is not a continuation
        cut = $urandom_range(1, n - 1);
        for (int k = 0; k < cut; k++)
            send_byte(seq_bytes[k], 1'b0, 1'b0, '0);
        if ($urandom_range(0, 1) == 0)
            send_byte(8'($urandom), 1'b1, 1'b0, '0);
        else begin
            junk = 8'($urandom);
            if (junk[7:6] == 2'b10)
                junk[6] = 1'b1;
            send_byte(junk, 1'b0, 1'b0, '0);
        end
    endtask

    // sink side: random ready bursts, one long hold-off, always ready at the end
    initial begin
        int cyc;
        int n;
        bit held;
        cyc  = 0;
        held = 1'b0;
        i_m_tready <= 1'b0;
        repeat (2) @(posedge i_clk);
        forever begin
            if (calm) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else if (!held && cyc >= 400) begin
                i_m_tready <= 1'b0;
                repeat (120) @(posedge i_clk);
                cyc  += 120;
                held = 1'b1;
            end else begin
                n = $urandom_range(1, 18);
                i_m_tready <= ($urandom_range(0, 2) != 0);
                repeat (n) @(posedge i_clk);
                cyc += n;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_results.size() == 0) begin
                $error("unexpected transfer: code_point %0h status %0d",
                       o_m_tdata[30:0], o_m_tuser);
                fail_count++;
            end else begin
                head_result = due_results.pop_front();
                if (o_m_tdata[30:0] !== head_result.code_point) begin
                    $error("code_point: expected %0h, actual %0h",
                           head_result.code_point, o_m_tdata[30:0]);
                    fail_count++;
                end
                if (o_m_tdata[33:31] !== head_result.seq_length) begin
                    $error("seq_length: expected %0d, actual %0d",
                           head_result.seq_length, o_m_tdata[33:31]);
                    fail_count++;
                end
                if (o_m_tuser !== head_result.status) begin
                    $error("status: expected %0d, actual %0d",
                           head_result.status, o_m_tuser);
                    fail_count++;
                end
                if (o_m_tdata[41:34] !== head_result.bad_byte) begin
                    $error("bad_byte: expected %0h, actual %0h",
                           head_result.bad_byte, o_m_tdata[41:34]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int directed_count;
        int waited;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= 1'b0;

        //        byte   eoi   typed cp            len   status                  bad
        add_byte(8'hA5, 1'b1, 1'b1, 31'h0,        3'd0, utf8v_pkg::ST_END,       8'h00);
        add_byte(8'h00, 1'b0, 1'b1, 31'h0,        3'd1, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'h7F, 1'b0, 1'b1, 31'h7F,       3'd1, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'hFE, 1'b0, 1'b1, 31'h0,        3'd1, utf8v_pkg::ST_BAD_LEAD,  8'hFE);
        add_byte(8'hFF, 1'b0, 1'b1, 31'h0,        3'd1, utf8v_pkg::ST_BAD_LEAD,  8'hFF);
        add_byte(8'hC2, 1'b0, 1'b0, 31'h0,        3'd0, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'h80, 1'b0, 1'b0, 31'h0,        3'd0, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'hC1, 1'b0, 1'b0, 31'h0,        3'd0, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'hBF, 1'b0, 1'b1, 31'h0,        3'd2, utf8v_pkg::ST_OVERLONG,  8'h00);
        add_byte(8'hE0, 1'b0, 1'b0, 31'h0,        3'd0, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'h41, 1'b0, 1'b1, 31'h0,        3'd3, utf8v_pkg::ST_BAD_CONT,  8'h41);
        // stray continuation right after an error is a bad lead
        add_byte(8'h80, 1'b0, 1'b1, 31'h0,        3'd1, utf8v_pkg::ST_BAD_LEAD,  8'h80);
        add_byte(8'hED, 1'b0, 1'b0, 31'h0,        3'd0, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'hA0, 1'b0, 1'b0, 31'h0,        3'd0, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'h80, 1'b0, 1'b1, 31'h0,        3'd3, utf8v_pkg::ST_SURROGATE, 8'h00);
        add_byte(8'hEF, 1'b0, 1'b0, 31'h0,        3'd0, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'hBF, 1'b0, 1'b0, 31'h0,        3'd0, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'hBF, 1'b0, 1'b1, 31'h0,        3'd3, utf8v_pkg::ST_NONCHAR,   8'h00);
        add_byte(8'hF0, 1'b0, 1'b0, 31'h0,        3'd0, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'h00, 1'b1, 1'b1, 31'h0,        3'd4, utf8v_pkg::ST_TRUNC,     8'h00);
        add_byte(8'hFD, 1'b0, 1'b0, 31'h0,        3'd0, utf8v_pkg::ST_OK,        8'h00);
        repeat (4)
            add_byte(8'hBF, 1'b0, 1'b0, 31'h0,    3'd0, utf8v_pkg::ST_OK,        8'h00);
        add_byte(8'hBF, 1'b0, 1'b1, 31'h7FFFFFFF, 3'd6, utf8v_pkg::ST_OK,        8'h00);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i].b, directed_bytes[i].eoi, directed_bytes[i].typed,
                      directed_bytes[i].want);

        directed_count = bytes_sent;
        while (bytes_sent < directed_count + 600) begin
            if (bytes_sent >= directed_count + 540)
                calm = 1'b1;
            send_sequence();
        end
        i_s_tvalid <= 1'b0;

        waited = 0;
        while (due_results.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d results never arrived", due_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
